/* rtl/fcpu_pkg.sv */
// Shared types, constants and tables for the fly camera pose update block.
package fcpu_pkg;

    typedef enum logic [3:0] {
        ST_IDLE, ST_YAW_MUL, ST_YAW_ADD, ST_PITCH_MUL, ST_PITCH_SUB,
        ST_WRAP_STEP, ST_WRAP_FIX, ST_COR_LOAD, ST_COR_ITER, ST_COR_END,
        ST_PROD_MUL, ST_PROD_WB, ST_MOVE, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PR_STEP, PR_FX, PR_FY, PR_MX, PR_MY, PR_MZ, PR_RX, PR_RY
    } prod_t;

    typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;

    typedef enum logic [2:0] {
        REG_MOVE_SPEED, REG_TURN_SENS, REG_START_X, REG_START_Y, REG_START_Z,
        REG_START_YAW, REG_START_PITCH
    } reg_idx_t;

    localparam logic signed [33:0] ANG_PI      = 34'sd52707179;
    localparam logic signed [33:0] ANG_PERIOD  = 34'sd105414357;
    localparam logic signed [33:0] ANG_HALF_PI = 34'sd26353589;
    localparam logic signed [33:0] PITCH_MAX   = 34'sd26353584;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [49:0] POS_MAX     = 50'sd140737488355327;
    localparam logic signed [49:0] POS_MIN     = -50'sd140737488355328;
    localparam logic [2:0]         WRAP_TOP    = 3'd5;
    localparam logic [3:0]         MOVE_LAST   = 4'd10;

    // Period scaled by 2^k, used by the restoring reduction of the yaw.
    function automatic logic [33:0] wrap_multiple(input logic [2:0] k);
        logic [33:0] p;
        p = 34'(ANG_PERIOD);
        return p << k;
    endfunction

    // Arctangent of 2^-i in 2^-24 rad.
    function automatic logic [23:0] atan_at(input logic [4:0] i);
        logic [23:0] v;
        case (i)
            5'd0:  v = 24'd13176795;
            5'd1:  v = 24'd7778716;
            5'd2:  v = 24'd4110060;
            5'd3:  v = 24'd2086331;
            5'd4:  v = 24'd1047214;
            5'd5:  v = 24'd524117;
            5'd6:  v = 24'd262123;
            5'd7:  v = 24'd131069;
            5'd8:  v = 24'd65536;
            5'd9:  v = 24'd32768;
            5'd10: v = 24'd16384;
            5'd11: v = 24'd8192;
            5'd12: v = 24'd4096;
            5'd13: v = 24'd2048;
            5'd14: v = 24'd1024;
            5'd15: v = 24'd512;
            5'd16: v = 24'd256;
            5'd17: v = 24'd128;
            5'd18: v = 24'd64;
            5'd19: v = 24'd32;
            5'd20: v = 24'd16;
            5'd21: v = 24'd8;
            5'd22: v = 24'd4;
            5'd23: v = 24'd2;
            5'd24: v = 24'd1;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/fly_camera_pose_update.sv */
// Top level of the fly camera pose update: sequencer, CORDIC, shared multiplier.
//
// One input beat per frame on the s_ channel carries the frame time, five key
// bits and the two mouse deltas. The block turns the camera, moves it when a
// key is held, and sends one result beat on the m_ channel with the new
// position, wrapped yaw and clamped pitch.
// With no key held the sequencer skips the CORDIC, product and move steps.
// Otherwise the work runs in turn on the single multiplier, used for the two
// mouse products and eight pose products, and on the one CORDIC unit that
// runs the yaw and then the pitch.
// s_tready is high only while the sequencer is idle; one item is in work at a
// time, so a new input beat is taken only once the sequencer is done with the
// last one. The result sits in an output register, so the next input beat is
// taken while a result still waits for m_tready. A stalled receiver only
// holds the sequencer at its last step until the register frees up.
// The APB port writes the speed, sensitivity and start pose. A start_yaw
// write runs a wrap pass during which s_tready stays low.
// Reset is synchronous on aresetn: the configuration registers return to their
// defaults and the pose to the origin with zero yaw and pitch.
module fly_camera_pose_update #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // delta_time[15:0], key_forward[16], key_left[17], key_backward[18],
    // key_right[19], key_up[20], mouse_dx[36:21], mouse_dy[52:37], zero pad
    input  logic [55:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x[47:0], pos_y[95:48], pos_z[143:96], yaw_out[170:144],
    // pitch_out[196:171], zero pad
    output logic [199:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    localparam int         NIT      = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
    localparam logic [4:0] COR_LAST = 5'(NIT - 1);

    fcpu_pkg::state_t state_reg, state_next;

    logic [31:0]        speed_reg;
    logic [15:0]        sens_reg;
    logic signed [47:0] start_x_reg, start_y_reg, start_z_reg;
    logic signed [31:0] start_yaw_reg, start_pitch_reg;
    logic signed [47:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [26:0] heading_reg;
    logic signed [25:0] elev_reg;
    logic [15:0]        dt_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic [4:0]         keys_reg;   // forward, left, backward, right, up
    logic signed [67:0] prod_reg;
    logic [32:0]        mag_reg;
    logic               neg_reg;
    logic [2:0]         k_reg;
    logic               wrap_cfg_reg;
    logic               pass_reg;
    logic               flip_reg;
    logic signed [32:0] cx_reg, cy_reg;
    logic signed [28:0] cz_reg;
    logic [4:0]         it_reg;
    logic signed [32:0] sin_yaw_reg, cos_yaw_reg, sin_pit_reg, cos_pit_reg;
    fcpu_pkg::prod_t    msel_reg;
    logic signed [33:0] step_reg, fx_reg, fy_reg, mx_reg, my_reg, mz_reg, rx_reg, ry_reg;
    logic [3:0]         move_cnt_reg;
    logic               m_tvalid_reg;
    logic [199:0]       m_tdata_reg;

    logic               s_acc, cfg_wr, out_free, any_key;
    logic [2:0]         cfg_idx;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] rnd30, rnd16;
    logic signed [33:0] yaw_sum, pitch_diff, cfg_yaw, cfg_pitch;
    logic signed [28:0] wrap_r, wrap_fixed, cor_a;
    logic [33:0]        wrap_cmp;
    logic signed [32:0] xs, ys;
    logic signed [28:0] at;
    logic               mv_en, mv_sub;
    fcpu_pkg::axis_t    mv_axis;
    logic signed [33:0] mv_d;
    logic signed [47:0] mv_cur;
    logic signed [49:0] mv_sum;
    logic signed [47:0] mv_sat;

    assign cfg_idx  = paddr[5:3];
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign any_key  = |keys_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;

    // Register read-back.
    always_comb begin
        case (fcpu_pkg::reg_idx_t'(cfg_idx))
            fcpu_pkg::REG_MOVE_SPEED:  prdata = 64'(speed_reg);
            fcpu_pkg::REG_TURN_SENS:   prdata = 64'(sens_reg);
            fcpu_pkg::REG_START_X:     prdata = 64'(start_x_reg);
            fcpu_pkg::REG_START_Y:     prdata = 64'(start_y_reg);
            fcpu_pkg::REG_START_Z:     prdata = 64'(start_z_reg);
            fcpu_pkg::REG_START_YAW:   prdata = 64'(start_yaw_reg);
            fcpu_pkg::REG_START_PITCH: prdata = 64'(start_pitch_reg);
            default:                   prdata = 64'd0;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fcpu_pkg::ST_IDLE: begin
                if (cfg_wr && cfg_idx == fcpu_pkg::REG_START_YAW)
                    state_next = fcpu_pkg::ST_WRAP_STEP;
                else if (s_acc)
                    state_next = fcpu_pkg::ST_YAW_MUL;
            end
            fcpu_pkg::ST_YAW_MUL:   state_next = fcpu_pkg::ST_YAW_ADD;
            fcpu_pkg::ST_YAW_ADD:   state_next = fcpu_pkg::ST_PITCH_MUL;
            fcpu_pkg::ST_PITCH_MUL: state_next = fcpu_pkg::ST_PITCH_SUB;
            fcpu_pkg::ST_PITCH_SUB: state_next = fcpu_pkg::ST_WRAP_STEP;
            fcpu_pkg::ST_WRAP_STEP: begin
                if (k_reg == 3'd0) state_next = fcpu_pkg::ST_WRAP_FIX;
            end
            fcpu_pkg::ST_WRAP_FIX: begin
                if (wrap_cfg_reg)  state_next = fcpu_pkg::ST_IDLE;
                else if (any_key)  state_next = fcpu_pkg::ST_COR_LOAD;
                else               state_next = fcpu_pkg::ST_DONE;
            end
            fcpu_pkg::ST_COR_LOAD:  state_next = fcpu_pkg::ST_COR_ITER;
            fcpu_pkg::ST_COR_ITER: begin
                if (it_reg == COR_LAST) state_next = fcpu_pkg::ST_COR_END;
            end
            fcpu_pkg::ST_COR_END: begin
                state_next = pass_reg ? fcpu_pkg::ST_PROD_MUL : fcpu_pkg::ST_COR_LOAD;
            end
            fcpu_pkg::ST_PROD_MUL:  state_next = fcpu_pkg::ST_PROD_WB;
            fcpu_pkg::ST_PROD_WB: begin
                state_next = (msel_reg == fcpu_pkg::PR_RY) ? fcpu_pkg::ST_MOVE
                                                           : fcpu_pkg::ST_PROD_MUL;
            end
            fcpu_pkg::ST_MOVE: begin
                if (move_cnt_reg == fcpu_pkg::MOVE_LAST) state_next = fcpu_pkg::ST_DONE;
            end
            fcpu_pkg::ST_DONE: begin
                if (out_free) state_next = fcpu_pkg::ST_IDLE;
            end
            default: state_next = fcpu_pkg::ST_IDLE;
        endcase
    end

    // Handshake and multiplier operand selection.
    always_comb begin
        s_tready = (state_reg == fcpu_pkg::ST_IDLE);
        mul_a    = 34'(dx_reg);
        mul_b    = 34'(sens_reg);
        case (state_reg)
            fcpu_pkg::ST_PITCH_MUL: begin
                mul_a = 34'(dy_reg);
                mul_b = 34'(sens_reg);
            end
            fcpu_pkg::ST_PROD_MUL: begin
                case (msel_reg)
                    fcpu_pkg::PR_STEP: begin mul_a = 34'(speed_reg); mul_b = 34'(dt_reg); end
                    fcpu_pkg::PR_FX:   begin mul_a = 34'(sin_yaw_reg); mul_b = 34'(cos_pit_reg); end
                    fcpu_pkg::PR_FY:   begin mul_a = 34'(cos_yaw_reg); mul_b = 34'(cos_pit_reg); end
                    fcpu_pkg::PR_MX:   begin mul_a = fx_reg; mul_b = step_reg; end
                    fcpu_pkg::PR_MY:   begin mul_a = fy_reg; mul_b = step_reg; end
                    fcpu_pkg::PR_MZ:   begin mul_a = 34'(sin_pit_reg); mul_b = step_reg; end
                    fcpu_pkg::PR_RX:   begin mul_a = 34'(cos_yaw_reg); mul_b = step_reg; end
                    fcpu_pkg::PR_RY:   begin mul_a = -34'(sin_yaw_reg); mul_b = step_reg; end
                    default:           begin mul_a = 34'd0; mul_b = 34'd0; end
                endcase
            end
            default: begin
                mul_a = 34'(dx_reg);
                mul_b = 34'(sens_reg);
            end
        endcase
    end

    // Datapath helpers.
    always_comb begin
        rnd30      = prod_reg + (68'sd1 <<< 29);
        rnd16      = prod_reg + (68'sd1 <<< 15);
        yaw_sum    = 34'(heading_reg) + prod_reg[33:0];
        pitch_diff = 34'(elev_reg) - prod_reg[33:0];
        cfg_yaw    = 34'($signed(pwdata[31:0]));
        cfg_pitch  = 34'($signed(pwdata[31:0]));
        wrap_cmp   = fcpu_pkg::wrap_multiple(k_reg);
        wrap_r     = neg_reg ? -29'($signed({1'b0, mag_reg[26:0]}))
                             : 29'($signed({1'b0, mag_reg[26:0]}));
        if (34'(wrap_r) > fcpu_pkg::ANG_PI)       wrap_fixed = wrap_r - 29'(fcpu_pkg::ANG_PERIOD);
        else if (34'(wrap_r) < -fcpu_pkg::ANG_PI) wrap_fixed = wrap_r + 29'(fcpu_pkg::ANG_PERIOD);
        else                                      wrap_fixed = wrap_r;
        cor_a = pass_reg ? 29'(elev_reg) : 29'(heading_reg);
        xs    = cx_reg >>> it_reg;
        ys    = cy_reg >>> it_reg;
        at    = 29'($signed({1'b0, fcpu_pkg::atan_at(it_reg)}));
    end

    // Position update order: forward, backward, right, left, up.
    always_comb begin
        mv_axis = fcpu_pkg::AX_X;
        mv_d    = mx_reg;
        mv_sub  = 1'b0;
        mv_en   = 1'b0;
        case (move_cnt_reg)
            4'd0:  begin mv_en = keys_reg[0]; mv_axis = fcpu_pkg::AX_X; mv_d = mx_reg; end
            4'd1:  begin mv_en = keys_reg[0]; mv_axis = fcpu_pkg::AX_Y; mv_d = my_reg; end
            4'd2:  begin mv_en = keys_reg[0]; mv_axis = fcpu_pkg::AX_Z; mv_d = mz_reg; end
            4'd3:  begin mv_en = keys_reg[2]; mv_axis = fcpu_pkg::AX_X; mv_d = mx_reg; mv_sub = 1'b1; end
            4'd4:  begin mv_en = keys_reg[2]; mv_axis = fcpu_pkg::AX_Y; mv_d = my_reg; mv_sub = 1'b1; end
            4'd5:  begin mv_en = keys_reg[2]; mv_axis = fcpu_pkg::AX_Z; mv_d = mz_reg; mv_sub = 1'b1; end
            4'd6:  begin mv_en = keys_reg[3]; mv_axis = fcpu_pkg::AX_X; mv_d = rx_reg; end
            4'd7:  begin mv_en = keys_reg[3]; mv_axis = fcpu_pkg::AX_Y; mv_d = ry_reg; end
            4'd8:  begin mv_en = keys_reg[1]; mv_axis = fcpu_pkg::AX_X; mv_d = rx_reg; mv_sub = 1'b1; end
            4'd9:  begin mv_en = keys_reg[1]; mv_axis = fcpu_pkg::AX_Y; mv_d = ry_reg; mv_sub = 1'b1; end
            4'd10: begin mv_en = keys_reg[4]; mv_axis = fcpu_pkg::AX_Z; mv_d = step_reg; end
            default: mv_en = 1'b0;
        endcase
        case (mv_axis)
            fcpu_pkg::AX_X: mv_cur = pos_x_reg;
            fcpu_pkg::AX_Y: mv_cur = pos_y_reg;
            fcpu_pkg::AX_Z: mv_cur = pos_z_reg;
            default:        mv_cur = pos_x_reg;
        endcase
        mv_sum = mv_sub ? (50'(mv_cur) - 50'(mv_d)) : (50'(mv_cur) + 50'(mv_d));
        if (mv_sum > fcpu_pkg::POS_MAX)      mv_sat = 48'(fcpu_pkg::POS_MAX);
        else if (mv_sum < fcpu_pkg::POS_MIN) mv_sat = 48'(fcpu_pkg::POS_MIN);
        else                                 mv_sat = mv_sum[47:0];
    end

    // Multiplier product register, payload only.
    always_ff @(posedge aclk) begin
        prod_reg    <= mul_a * mul_b;
        m_tdata_reg <= m_tdata_reg;
        if (state_reg == fcpu_pkg::ST_DONE && out_free)
            m_tdata_reg <= {3'b000, elev_reg, heading_reg, pos_z_reg, pos_y_reg, pos_x_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= fcpu_pkg::ST_IDLE;
            speed_reg       <= 32'd327680;
            sens_reg        <= 16'd33554;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            start_z_reg     <= '0;
            start_yaw_reg   <= '0;
            start_pitch_reg <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            pos_z_reg       <= '0;
            heading_reg     <= '0;
            elev_reg        <= '0;
            keys_reg        <= '0;
            wrap_cfg_reg    <= 1'b0;
            pass_reg        <= 1'b0;
            it_reg          <= '0;
            k_reg           <= '0;
            msel_reg        <= fcpu_pkg::PR_STEP;
            move_cnt_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;

            if (cfg_wr) begin
                case (fcpu_pkg::reg_idx_t'(cfg_idx))
                    fcpu_pkg::REG_MOVE_SPEED: speed_reg <= pwdata[31:0];
                    fcpu_pkg::REG_TURN_SENS:  sens_reg  <= pwdata[15:0];
                    fcpu_pkg::REG_START_X: begin
                        start_x_reg <= pwdata[47:0];
                        pos_x_reg   <= pwdata[47:0];
                    end
                    fcpu_pkg::REG_START_Y: begin
                        start_y_reg <= pwdata[47:0];
                        pos_y_reg   <= pwdata[47:0];
                    end
                    fcpu_pkg::REG_START_Z: begin
                        start_z_reg <= pwdata[47:0];
                        pos_z_reg   <= pwdata[47:0];
                    end
                    fcpu_pkg::REG_START_YAW: begin
                        // The wrap runs through the same reduction as a step.
                        start_yaw_reg <= pwdata[31:0];
                        neg_reg       <= cfg_yaw[33];
                        mag_reg       <= cfg_yaw[33] ? 33'(-cfg_yaw) : cfg_yaw[32:0];
                        k_reg         <= fcpu_pkg::WRAP_TOP;
                        wrap_cfg_reg  <= 1'b1;
                    end
                    fcpu_pkg::REG_START_PITCH: begin
                        start_pitch_reg <= pwdata[31:0];
                        if (cfg_pitch > fcpu_pkg::PITCH_MAX)       elev_reg <= 26'(fcpu_pkg::PITCH_MAX);
                        else if (cfg_pitch < -fcpu_pkg::PITCH_MAX) elev_reg <= 26'(-fcpu_pkg::PITCH_MAX);
                        else                                       elev_reg <= cfg_pitch[25:0];
                    end
                    default: ;
                endcase
            end

            case (state_reg)
                fcpu_pkg::ST_IDLE: begin
                    if (s_acc) begin
                        dt_reg       <= s_tdata[15:0];
                        keys_reg     <= s_tdata[20:16];
                        dx_reg       <= s_tdata[36:21];
                        dy_reg       <= s_tdata[52:37];
                        wrap_cfg_reg <= 1'b0;
                    end
                end
                fcpu_pkg::ST_YAW_ADD: begin
                    neg_reg <= yaw_sum[33];
                    mag_reg <= yaw_sum[33] ? 33'(-yaw_sum) : yaw_sum[32:0];
                    k_reg   <= fcpu_pkg::WRAP_TOP;
                end
                fcpu_pkg::ST_PITCH_SUB: begin
                    if (pitch_diff > fcpu_pkg::PITCH_MAX)       elev_reg <= 26'(fcpu_pkg::PITCH_MAX);
                    else if (pitch_diff < -fcpu_pkg::PITCH_MAX) elev_reg <= 26'(-fcpu_pkg::PITCH_MAX);
                    else                                        elev_reg <= pitch_diff[25:0];
                end
                fcpu_pkg::ST_WRAP_STEP: begin
                    if (34'(mag_reg) >= wrap_cmp) mag_reg <= 33'(34'(mag_reg) - wrap_cmp);
                    k_reg <= k_reg - 3'd1;
                end
                fcpu_pkg::ST_WRAP_FIX: begin
                    heading_reg <= wrap_fixed[26:0];
                    pass_reg    <= 1'b0;
                end
                fcpu_pkg::ST_COR_LOAD: begin
                    // Fold the angle into the CORDIC range, negate at the end.
                    if (34'(cor_a) > fcpu_pkg::ANG_HALF_PI) begin
                        cz_reg   <= cor_a - 29'(fcpu_pkg::ANG_PI);
                        flip_reg <= 1'b1;
                    end else if (34'(cor_a) < -fcpu_pkg::ANG_HALF_PI) begin
                        cz_reg   <= cor_a + 29'(fcpu_pkg::ANG_PI);
                        flip_reg <= 1'b1;
                    end else begin
                        cz_reg   <= cor_a;
                        flip_reg <= 1'b0;
                    end
                    cx_reg <= fcpu_pkg::CORDIC_GAIN;
                    cy_reg <= '0;
                    it_reg <= '0;
                end
                fcpu_pkg::ST_COR_ITER: begin
                    if (!cz_reg[28]) begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - at;
                    end else begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + at;
                    end
                    if (it_reg != COR_LAST) it_reg <= it_reg + 5'd1;
                end
                fcpu_pkg::ST_COR_END: begin
                    if (pass_reg) begin
                        sin_pit_reg <= flip_reg ? -cy_reg : cy_reg;
                        cos_pit_reg <= flip_reg ? -cx_reg : cx_reg;
                    end else begin
                        sin_yaw_reg <= flip_reg ? -cy_reg : cy_reg;
                        cos_yaw_reg <= flip_reg ? -cx_reg : cx_reg;
                    end
                    pass_reg <= 1'b1;
                    msel_reg <= fcpu_pkg::PR_STEP;
                end
                fcpu_pkg::ST_PROD_WB: begin
                    case (msel_reg)
                        fcpu_pkg::PR_STEP: step_reg <= rnd16[49:16];
                        fcpu_pkg::PR_FX:   fx_reg   <= rnd30[63:30];
                        fcpu_pkg::PR_FY:   fy_reg   <= rnd30[63:30];
                        fcpu_pkg::PR_MX:   mx_reg   <= rnd30[63:30];
                        fcpu_pkg::PR_MY:   my_reg   <= rnd30[63:30];
                        fcpu_pkg::PR_MZ:   mz_reg   <= rnd30[63:30];
                        fcpu_pkg::PR_RX:   rx_reg   <= rnd30[63:30];
                        fcpu_pkg::PR_RY:   ry_reg   <= rnd30[63:30];
                        default: ;
                    endcase
                    msel_reg     <= fcpu_pkg::prod_t'(msel_reg + 3'd1);
                    move_cnt_reg <= '0;
                end
                fcpu_pkg::ST_MOVE: begin
                    if (mv_en) begin
                        case (mv_axis)
                            fcpu_pkg::AX_X: pos_x_reg <= mv_sat;
                            fcpu_pkg::AX_Y: pos_y_reg <= mv_sat;
                            fcpu_pkg::AX_Z: pos_z_reg <= mv_sat;
                            default: ;
                        endcase
                    end
                    move_cnt_reg <= move_cnt_reg + 4'd1;
                end
                fcpu_pkg::ST_DONE: begin
                    if (out_free) m_tvalid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // A finished wrap always leaves the heading inside [-pi, pi].
    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == fcpu_pkg::ST_WRAP_FIX |=>
            (34'(heading_reg) <= fcpu_pkg::ANG_PI && 34'(heading_reg) >= -fcpu_pkg::ANG_PI))
        else $error("heading left the wrapped range");

    // Pitch never leaves its clamp limits.
    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        34'(elev_reg) <= fcpu_pkg::PITCH_MAX && 34'(elev_reg) >= -fcpu_pkg::PITCH_MAX)
        else $error("pitch outside clamp limits");

    // A result appears only from the final sequencer step.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == fcpu_pkg::ST_DONE))
        else $error("result beat raised outside the done step");

    // The reduction has brought the yaw magnitude below one period before the wrap is finished.
    a_wrap_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == fcpu_pkg::ST_WRAP_FIX |-> mag_reg < 33'(fcpu_pkg::ANG_PERIOD))
        else $error("yaw reduction incomplete");

endmodule
